@@ hdl/pdtp_pkg.sv @@
// ----------------------------------------------------------------------------
// pdtp_pkg: shared types and constants of the disciplined tick period block
// Field widths, register indexes, event codes and loop filter limits.
// ----------------------------------------------------------------------------
package pdtp_pkg;

    // Field widths
    localparam int COUNT_W    = 24;  // tick_count
    localparam int PERIOD_W   = 24;  // period_ticks and period register
    localparam int NOM_W      = 16;  // nominal_period
    localparam int BLANK_W    = 8;   // blank_periods and blank counter
    localparam int SUM_W      = 32;  // integral accumulator
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Upper saturation bound of the new period is 2^COUNT_BITS - 1
    localparam int COUNT_BITS = 24;

    // Width of the signed new-period sum, wide enough for COUNT_BITS up to 32
    localparam int NP_W = 34;
    localparam logic signed [NP_W-1:0] NP_MAX = NP_W'((64'd1 << COUNT_BITS) - 64'd1);
    localparam logic signed [NP_W-1:0] NP_MIN = NP_W'(1);

    localparam logic [SUM_W-1:0] SUM_POS_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_NEG_MAX = {1'b1, {(SUM_W-1){1'b0}}};

    // Reset values of the configuration registers
    localparam logic [NOM_W-1:0]   NOMINAL_RESET = NOM_W'(327);
    localparam logic [BLANK_W-1:0] BLANK_RESET   = BLANK_W'(28);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NOMINAL_PERIOD = 8'd0,
        REG_BLANK_PERIODS  = 8'd1
    } t_reg_idx;

    // Event kinds
    typedef enum logic {
        EV_EDGE       = 1'b0,
        EV_PERIOD_END = 1'b1
    } t_event;

    // Control results from the qualifier to the loop filter and result stage
    typedef struct packed {
        logic fire;        // edge qualified, run the loop
        logic blanking;    // blank counter nonzero after this request
        logic tick_pulse;  // request was a period end
    } t_ctrl;

endpackage

@@ hdl/pdtp_ctrl.sv @@
// ----------------------------------------------------------------------------
// pdtp_ctrl: edge qualifier and blanking control
// Holds the edge-taken flag and blank counter, qualifies external edges.
// ----------------------------------------------------------------------------
module pdtp_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic                         i_req_type,
    input  logic [pdtp_pkg::COUNT_W-1:0] i_tick_count,
    input  logic [pdtp_pkg::NOM_W-1:0]   i_nominal,
    input  logic [pdtp_pkg::BLANK_W-1:0] i_blank_periods,
    output pdtp_pkg::t_ctrl              o_ctrl
);

    logic                         r_edge_taken;
    logic                         n_edge_taken;
    logic [pdtp_pkg::BLANK_W-1:0] r_blank;
    logic [pdtp_pkg::BLANK_W-1:0] n_blank;
    logic [pdtp_pkg::NOM_W+1:0]   w_hi;
    logic [pdtp_pkg::NOM_W-1:0]   w_lo;
    logic                         w_in_window;
    logic                         w_is_edge;

    // Acceptance window: nominal/4 .. nominal*3/4
    assign w_hi        = ({2'b00, i_nominal} + {1'b0, i_nominal, 1'b0}) >> 2;
    assign w_lo        = i_nominal >> 2;
    assign w_in_window = (i_tick_count >= pdtp_pkg::COUNT_W'(w_lo)) &&
                         (i_tick_count <= pdtp_pkg::COUNT_W'(w_hi));
    assign w_is_edge   = (i_req_type == pdtp_pkg::EV_EDGE);

    always_comb begin
        n_edge_taken = r_edge_taken;
        n_blank      = r_blank;
        o_ctrl.fire  = 1'b0;
        if (w_is_edge) begin
            if (!r_edge_taken && w_in_window && (r_blank == '0)) begin
                o_ctrl.fire  = 1'b1;
                n_edge_taken = 1'b1;
            end
        end else begin
            // Count down blanking, or start it after a period with no edge
            if (r_blank != '0) begin
                n_blank = r_blank - 1'b1;
            end else if (!r_edge_taken) begin
                n_blank = i_blank_periods;
            end
            n_edge_taken = 1'b0;
        end
        o_ctrl.blanking   = (n_blank != '0);
        o_ctrl.tick_pulse = !w_is_edge;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_taken <= 1'b0;
            r_blank      <= '0;
        end else if (i_step) begin
            r_edge_taken <= n_edge_taken;
            r_blank      <= n_blank;
        end
    end

endmodule

@@ hdl/pdtp_loop.sv @@
// ----------------------------------------------------------------------------
// pdtp_loop: PI loop filter
// Holds the integral sum and the period register, computes the new period.
// ----------------------------------------------------------------------------
module pdtp_loop (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic                          i_fire,
    input  logic [pdtp_pkg::COUNT_W-1:0]  i_tick_count,
    input  logic [pdtp_pkg::NOM_W-1:0]    i_nominal,
    output logic [pdtp_pkg::PERIOD_W-1:0] o_period
);

    logic [pdtp_pkg::SUM_W-1:0]       r_sum;
    logic [pdtp_pkg::SUM_W-1:0]       n_sum;
    logic [pdtp_pkg::PERIOD_W-1:0]    r_period;
    logic [pdtp_pkg::PERIOD_W-1:0]    n_period;

    logic signed [26:0]               w_diff;      // 2*count - period
    logic signed [33:0]               w_err;       // 64 * w_diff
    logic signed [33:0]               w_sum_raw;
    logic signed [32:0]               w_sum_bias;
    logic signed [23:0]               w_q;         // sum / 512
    logic signed [28:0]               w_corr_pre;  // err/32 + sum/512
    logic signed [28:0]               w_corr_bias;
    logic signed [21:0]               w_corr;      // (...) / 128
    logic signed [pdtp_pkg::NP_W-1:0] w_np;

    always_comb begin
        w_diff    = $signed({2'b00, i_tick_count, 1'b0}) - $signed({3'b000, r_period});
        w_err     = $signed({w_diff[26], w_diff, 6'b000000});
        w_sum_raw = $signed({{2{r_sum[31]}}, r_sum}) + w_err;

        // Saturate the sum to the signed 32-bit range
        if ((w_sum_raw[33:31] == 3'b000) || (w_sum_raw[33:31] == 3'b111)) begin
            n_sum = w_sum_raw[31:0];
        end else if (w_sum_raw[33]) begin
            n_sum = pdtp_pkg::SUM_NEG_MAX;
        end else begin
            n_sum = pdtp_pkg::SUM_POS_MAX;
        end

        // Divisions truncate toward zero: bias negative values before the shift
        w_sum_bias  = $signed({n_sum[31], n_sum}) + (n_sum[31] ? 33'sd511 : 33'sd0);
        w_q         = w_sum_bias[32:9];
        // err/32 is exactly 2*w_diff
        w_corr_pre  = $signed({w_diff[26], w_diff, 1'b0}) + $signed({{5{w_q[23]}}, w_q});
        w_corr_bias = w_corr_pre + (w_corr_pre[28] ? 29'sd127 : 29'sd0);
        w_corr      = w_corr_bias[28:7];

        w_np = $signed({{(pdtp_pkg::NP_W - pdtp_pkg::NOM_W){1'b0}}, i_nominal}) +
               $signed({{(pdtp_pkg::NP_W - 22){w_corr[21]}}, w_corr});

        if (w_np < pdtp_pkg::NP_MIN) begin
            n_period = pdtp_pkg::PERIOD_W'(pdtp_pkg::NP_MIN);
        end else if (w_np > pdtp_pkg::NP_MAX) begin
            n_period = pdtp_pkg::PERIOD_W'(pdtp_pkg::NP_MAX);
        end else begin
            n_period = w_np[pdtp_pkg::PERIOD_W-1:0];
        end
    end

    assign o_period = i_fire ? n_period : r_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_period <= pdtp_pkg::PERIOD_W'(pdtp_pkg::NOMINAL_RESET);
        end else if (i_step && i_fire) begin
            r_sum    <= n_sum;
            r_period <= n_period;
        end
    end

endmodule

@@ hdl/pi_disciplined_tick_period_top.sv @@
// ----------------------------------------------------------------------------
// pi_disciplined_tick_period_top: PI-disciplined local tick period
// Locks a local tick period to an external clock with a PI loop filter.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_in_valid / o_in_ready) carries one event: i_req_type
//   selects an external clock edge or a local period end, i_tick_count is the
//   tick counter value at the event. Every request gives exactly one result on
//   the result channel (o_out_valid / i_out_ready): the period after the event,
//   whether the edge updated the loop, the blanking state, and the tick pulse.
//   Configuration writes (i_cfg_valid / o_cfg_ready, always ready) set the
//   nominal period (index 0) and the blanking length (index 1); other indexes
//   are dropped. Write them only while no request is in flight.
//   A request is first captured in the input register; it is evaluated from
//   there and its result is shown once it is loaded into the result register.
//   Throughput: one request per cycle unless the receiver stalls. The
//   input register feeds a single pass of shifts and adds into the result
//   register; qualifier and loop filter state update in that same cycle.
//   When the receiver stalls, the result register holds and one more request
//   waits in the input register; o_in_ready then drops until the result moves.
//   Reset clears the integral sum, the edge flag and the blank counter, and
//   loads the nominal period (327) and blanking length (28) defaults.
// ----------------------------------------------------------------------------
module pi_disciplined_tick_period_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Request channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_req_type,
    input  logic [pdtp_pkg::COUNT_W-1:0]     i_tick_count,
    // Result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [pdtp_pkg::PERIOD_W-1:0]    o_period_ticks,
    output logic                             o_edge_accepted,
    output logic                             o_blanking,
    output logic                             o_tick_pulse,
    // Configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pdtp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pdtp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // Configuration registers
    logic [pdtp_pkg::NOM_W-1:0]    r_nominal;
    logic [pdtp_pkg::BLANK_W-1:0]  r_blank_periods;

    // Input register
    logic                          r_in_valid;
    logic                          r_req_type;
    logic [pdtp_pkg::COUNT_W-1:0]  r_tick_count;

    // Result register
    logic                          r_out_valid;
    logic [pdtp_pkg::PERIOD_W-1:0] r_period_ticks;
    logic                          r_edge_accepted;
    logic                          r_blanking;
    logic                          r_tick_pulse;

    logic                          w_step;
    pdtp_pkg::t_ctrl               w_ctrl;
    logic [pdtp_pkg::PERIOD_W-1:0] w_period;

    // Advance the held request whenever the result register is free or draining
    assign w_step      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_step;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nominal       <= pdtp_pkg::NOMINAL_RESET;
            r_blank_periods <= pdtp_pkg::BLANK_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pdtp_pkg::REG_NOMINAL_PERIOD: r_nominal       <= i_cfg_data;
                pdtp_pkg::REG_BLANK_PERIODS:  r_blank_periods <= i_cfg_data[pdtp_pkg::BLANK_W-1:0];
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    // Input register: control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Input register: payload
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_req_type   <= i_req_type;
            r_tick_count <= i_tick_count;
        end
    end

    pdtp_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_step),
        .i_req_type      (r_req_type),
        .i_tick_count    (r_tick_count),
        .i_nominal       (r_nominal),
        .i_blank_periods (r_blank_periods),
        .o_ctrl          (w_ctrl)
    );

    pdtp_loop u_loop (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_fire       (w_ctrl.fire),
        .i_tick_count (r_tick_count),
        .i_nominal    (r_nominal),
        .o_period     (w_period)
    );

    // Result register: control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register: payload
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_period_ticks  <= w_period;
            r_edge_accepted <= w_ctrl.fire;
            r_blanking      <= w_ctrl.blanking;
            r_tick_pulse    <= w_ctrl.tick_pulse;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_period_ticks  = r_period_ticks;
    assign o_edge_accepted = r_edge_accepted;
    assign o_blanking      = r_blanking;
    assign o_tick_pulse    = r_tick_pulse;

    // An event is either an accepted edge or a period end, never both
    a_accept_excl_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_edge_accepted && o_tick_pulse))
        else $error("edge accepted on a period end result");

    // The disciplined period never reaches zero
    a_period_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_period_ticks != '0))
        else $error("period register is zero");

    // Requests are refused only while a full pipeline is stalled
    a_ready_only_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("request refused without a stall");

    // A period end request always yields a tick pulse in the next result
    a_tick_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && (r_req_type == pdtp_pkg::EV_PERIOD_END)) |=> (o_out_valid && o_tick_pulse))
        else $error("period end lost its tick pulse");

endmodule
